FILE: hw/rtl/pss_pkg.sv
// ----------------------------------------------------------------------------
// Priority scheduler package
// Shared depth constants, word types, table entry and sequencer states.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [7:0]  job_id;
    logic [7:0]  job_priority;
    logic [15:0] burst_ticks;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    logic        busy_res;
    logic [7:0]  running_id;
    logic        started;
    logic        completed;
    logic [31:0] tick_time;
    logic [4:0]  waiting_count;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  pri;
    logic [15:0] burst;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RUN,
    ST_RESP
  } state_e;

  // Fill count as reported, masked to five bits.
  function automatic logic [4:0] fill_report(input logic [FILL_W-1:0] fill);
    logic [FILL_W+4:0] w;
    w = {5'b0, fill};
    return w[4:0];
  endfunction

endpackage

FILE: hw/rtl/pss_ram.sv
// ----------------------------------------------------------------------------
// Waiting table storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pss_ram import pss_pkg::*; (
  input  logic     clk_i,
  input  ram_req_t req_i,
  output entry_t   rdata_o
);

  entry_t mem_q [QUEUE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/nonpreemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// Non-preemptive priority scheduler
// Arrival-ordered waiting table; a tick with no running job picks the lowest
// priority value (earliest on ties), closes the gap and runs one tick.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+------------
//   in      | input     | in_valid_i / in_stall_o | in_word_i
//   out     | output    | out_valid_o / out_stall_i | out_word_o
//
// An arrive goes from idle straight to the response state; a tick with a
// job already running (or an empty table) passes through the run state
// first. A tick that starts a job scans the table one entry per cycle through
// the single read port, then shifts the later entries down one per cycle.
// Reset clears the fill count, run state and time; the table is not cleared.
// A result waits in the output register while the next word is accepted.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler import pss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  state_e            state_q, state_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              run_vld_q, run_vld_d;
  logic [7:0]        run_id_q, run_id_d;
  logic [15:0]       run_left_q, run_left_d;
  logic [31:0]       now_q, now_d;
  logic [31:0]       tick_time_q, tick_time_d;
  logic              started_q, started_d;
  logic [FILL_W-1:0] scan_q, scan_d;
  logic              rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;
  entry_t            best_q, best_d;
  out_word_t         res_q, res_d;
  out_word_t         out_q, out_d;
  logic              out_vld_q, out_vld_d;

  ram_req_t          ram_req;
  entry_t            rd_data;
  logic              in_acc;
  logic              out_free;
  logic [FILL_W-1:0] fill_m1;
  logic [IDX_W-1:0]  last_idx;
  logic              scan_issue;
  logic              scan_last;
  logic              shift_done;

  pss_ram u_ram (
    .clk_i  (clk_i),
    .req_i  (ram_req),
    .rdata_o(rd_data)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_vld_q || !out_stall_i;
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  assign fill_m1    = fill_q - FILL_W'(1);
  assign last_idx   = fill_m1[IDX_W-1:0];
  assign scan_issue = (scan_q < fill_q);
  assign scan_last  = rd_vld_q && (rd_idx_q == last_idx);
  assign shift_done = scan_last || (!rd_vld_q && !scan_issue);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_word_i.operation == OP_TICK) begin
            if (!run_vld_q && (fill_q != '0)) state_d = ST_SCAN;
            else                              state_d = ST_RUN;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_SCAN:  if (scan_last)  state_d = ST_SHIFT;
      ST_SHIFT: if (shift_done) state_d = ST_RUN;
      ST_RUN:   state_d = ST_RESP;
      ST_RESP:  if (out_free)   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and table access
  always_comb begin
    fill_d      = fill_q;
    run_vld_d   = run_vld_q;
    run_id_d    = run_id_q;
    run_left_d  = run_left_q;
    now_d       = now_q;
    tick_time_d = tick_time_q;
    started_d   = started_q;
    scan_d      = scan_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    res_d       = res_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q && out_stall_i;

    ram_req.we    = 1'b0;
    ram_req.waddr = fill_q[IDX_W-1:0];
    ram_req.wdata = '{id: in_word_i.job_id, pri: in_word_i.job_priority,
                      burst: in_word_i.burst_ticks};
    ram_req.raddr = scan_q[IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_d = '0;
          if (in_word_i.operation == OP_TICK) begin
            tick_time_d = now_q;
            now_d       = now_q + 32'd1;
            started_d   = 1'b0;
            scan_d      = '0;
          end else if (fill_q < FILL_W'(QUEUE_DEPTH)) begin
            ram_req.we          = 1'b1;
            fill_d              = fill_q + FILL_W'(1);
            res_d.accepted      = 1'b1;
            res_d.waiting_count = fill_report(fill_d);
          end else begin
            res_d.waiting_count = fill_report(fill_q);
          end
        end
      end
      ST_SCAN: begin
        if (scan_issue) begin
          rd_vld_d = 1'b1;
          rd_idx_d = scan_q[IDX_W-1:0];
          scan_d   = scan_q + FILL_W'(1);
        end
        // strict compare keeps the earliest arrival on ties
        if (rd_vld_q && ((rd_idx_q == '0) || (rd_data.pri < best_q.pri))) begin
          best_d     = rd_data;
          best_idx_d = rd_idx_q;
        end
        if (scan_last) begin
          scan_d = FILL_W'(best_idx_d) + FILL_W'(1);
        end
      end
      ST_SHIFT: begin
        if (scan_issue) begin
          rd_vld_d = 1'b1;
          rd_idx_d = scan_q[IDX_W-1:0];
          scan_d   = scan_q + FILL_W'(1);
        end
        // move each later entry down by one to close the gap
        if (rd_vld_q) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = rd_idx_q - IDX_W'(1);
          ram_req.wdata = rd_data;
        end
        if (shift_done) begin
          fill_d     = fill_m1;
          run_vld_d  = 1'b1;
          run_id_d   = best_q.id;
          run_left_d = best_q.burst;
          started_d  = 1'b1;
        end
      end
      ST_RUN: begin
        res_d               = '0;
        res_d.tick_time     = tick_time_q;
        res_d.started       = started_q;
        res_d.waiting_count = fill_report(fill_q);
        if (run_vld_q) begin
          res_d.busy_res   = 1'b1;
          res_d.running_id = run_id_q;
          if (run_left_q <= 16'd1) begin
            res_d.completed = 1'b1;
            run_vld_d       = 1'b0;
            run_left_d      = '0;
          end else begin
            run_left_d = run_left_q - 16'd1;
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_q     <= '0;
      run_vld_q  <= 1'b0;
      run_id_q   <= '0;
      run_left_q <= '0;
      now_q      <= '0;
      rd_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      run_vld_q  <= run_vld_d;
      run_id_q   <= run_id_d;
      run_left_q <= run_left_d;
      now_q      <= now_d;
      rd_vld_q   <= rd_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tick_time_q <= tick_time_d;
    started_q   <= started_d;
    scan_q      <= scan_d;
    rd_idx_q    <= rd_idx_d;
    best_idx_q  <= best_idx_d;
    best_q      <= best_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(QUEUE_DEPTH))
    else $error("waiting table fill exceeds depth");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !ram_req.we)
    else $error("table written during selection scan");

  a_start_loads_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT && state_d == ST_RUN) |=> (run_vld_q && started_q))
    else $error("selected job not loaded");

  a_complete_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.completed) |-> out_q.busy_res)
    else $error("completion reported on idle tick");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && state_d == ST_SCAN) |-> (fill_q != '0 && !run_vld_q))
    else $error("scan started with nothing to pick");

endmodule

FILE: tb/nonpreemptive_priority_scheduler_tb.sv
// ----------------------------------------------------------------------------
// Priority scheduler testbench
// Sends directed, then random, arrive and tick words through the valid/stall
// channels. Each result is checked field by field against a typed row's word
// or a local scheduler model's. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler_tb;
  import pss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIRECTED_ROWS = 25;
  localparam int PHASE_ITEMS   = 500;
  localparam int DRAIN_CYCLES  = 40;
  localparam int MAX_PRINTS    = 40;
  localparam logic PREDICT     = 1'b0;
  localparam logic TYPED       = 1'b1;

  typedef struct packed {
    in_word_t  word;
    logic      typed;
    out_word_t res;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_word_t  in_word   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_word_t out_word;

  int        send_idle_pct = 0;
  int        stall_pct     = 0;
  int        errors        = 0;
  int        results_seen  = 0;
  out_word_t want_res;
  out_word_t sched_results_due[$];
  dir_row_t  directed_rows[DIRECTED_ROWS];

  // Scheduler model state
  entry_t      sched_table[QUEUE_DEPTH];
  int unsigned sched_fill    = 0;
  logic        run_busy      = 1'b0;
  logic [7:0]  run_job       = '0;
  logic [15:0] run_remaining = '0;
  logic [31:0] clock_ticks   = '0;

  nonpreemptive_priority_scheduler i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  always begin
    #4ns clk = 1'b1;
    #4ns clk = 1'b0;
  end

  function automatic in_word_t arrive_word(logic [7:0] id, logic [7:0] pri,
                                           logic [15:0] burst);
    return {OP_ARRIVE, id, pri, burst};
  endfunction

  function automatic in_word_t tick_word();
    return {OP_TICK, 8'h00, 8'h00, 16'h0000};
  endfunction

  // Result with no job activity: arrive outcome or idle tick.
  function automatic out_word_t quiet_res(logic acc, logic [31:0] t, logic [4:0] cnt);
    return {acc, 1'b0, 8'h00, 1'b0, 1'b0, t, cnt};
  endfunction

  function automatic out_word_t schedule_step(in_word_t w);
    out_word_t   r;
    int unsigned pick;
    r = '0;
    if (w.operation == OP_ARRIVE) begin
      if (sched_fill < QUEUE_DEPTH) begin
        sched_table[sched_fill] = {w.job_id, w.job_priority, w.burst_ticks};
        sched_fill++;
        r.accepted = 1'b1;
      end
    end else begin
      r.tick_time = clock_ticks;
      if (!run_busy && sched_fill > 0) begin
        // lowest value wins; strict compare keeps the earliest on ties
        pick = 0;
        for (int unsigned i = 1; i < sched_fill; i++)
          if (sched_table[i].pri < sched_table[pick].pri) pick = i;
        run_job       = sched_table[pick].id;
        run_remaining = sched_table[pick].burst;
        run_busy      = 1'b1;
        for (int unsigned i = pick; i + 1 < sched_fill; i++)
          sched_table[i] = sched_table[i + 1];
        sched_fill--;
        r.started = 1'b1;
      end
      if (run_busy) begin
        r.busy_res   = 1'b1;
        r.running_id = run_job;
        if (run_remaining <= 16'd1) begin
          run_remaining = '0;
          run_busy      = 1'b0;
          r.completed   = 1'b1;
        end else begin
          run_remaining--;
        end
      end
      clock_ticks++;
    end
    r.waiting_count = sched_fill[4:0];
    return r;
  endfunction

  function automatic in_word_t random_word(int arrive_pct);
    in_word_t w;
    w.operation    = ($urandom_range(99) < arrive_pct) ? OP_ARRIVE : OP_TICK;
    w.job_id       = 8'($urandom_range(255));
    // narrow priorities half the time so ties are common
    w.job_priority = ($urandom_range(1) == 0) ? 8'($urandom_range(3))
                                               : 8'($urandom_range(255));
    if (w.operation == OP_TICK || sched_fill >= QUEUE_DEPTH)
      w.burst_ticks = 16'($urandom_range(65535));
    else if ($urandom_range(99) < 85)
      w.burst_ticks = 16'($urandom_range(3));
    else
      w.burst_ticks = 16'($urandom_range(20));
    return w;
  endfunction

  task automatic report_error(string msg);
    if (errors < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_error($sformatf("word %0d %s: got %0h, want %0h",
                             results_seen, name, got, want));
  endtask

  // Present one word, hold it through stalls, then record its expected result.
  task automatic send_word(in_word_t word, logic typed, out_word_t typed_res);
    logic      took;
    out_word_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= word;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    predicted = schedule_step(word);
    sched_results_due = {sched_results_due, (typed ? typed_res : predicted)};
  endtask

  task automatic wait_drained();
    while (sched_results_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // out_stall only moves at the rising edge, so the negedge view decides
  // whether the word is taken at the next edge.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (sched_results_due.size() == 0) begin
        report_error($sformatf("unexpected result word %0h", out_word));
      end else begin
        want_res = sched_results_due.pop_front();
        compare_field("accepted", 32'(out_word.accepted), 32'(want_res.accepted));
        compare_field("busy_res", 32'(out_word.busy_res), 32'(want_res.busy_res));
        compare_field("running_id", 32'(out_word.running_id),
                      32'(want_res.running_id));
        compare_field("started", 32'(out_word.started), 32'(want_res.started));
        compare_field("completed", 32'(out_word.completed),
                      32'(want_res.completed));
        compare_field("tick_time", out_word.tick_time, want_res.tick_time);
        compare_field("waiting_count", 32'(out_word.waiting_count),
                      32'(want_res.waiting_count));
      end
      results_seen++;
    end
  end

  initial begin
    directed_rows = '{
      {tick_word(),                         TYPED,   quiet_res(1'b0, 32'd0, 5'd0)},
      {arrive_word(8'h00, 8'h80, 16'h0000), TYPED,   quiet_res(1'b1, 32'd0, 5'd1)},
      {tick_word(),                         PREDICT, out_word_t'('0)},
      {arrive_word(8'h01, 8'h05, 16'h0002), PREDICT, out_word_t'('0)},
      {arrive_word(8'h02, 8'h05, 16'h0001), PREDICT, out_word_t'('0)},
      {arrive_word(8'h03, 8'h00, 16'h0001), PREDICT, out_word_t'('0)},
      {tick_word(),                         PREDICT, out_word_t'('0)},
      {tick_word(),                         PREDICT, out_word_t'('0)},
      {arrive_word(8'h04, 8'h00, 16'h0001), PREDICT, out_word_t'('0)},
      {tick_word(),                         PREDICT, out_word_t'('0)},
      {arrive_word(8'hFF, 8'hFF, 16'h0003), PREDICT, out_word_t'('0)},
      {arrive_word(8'h00, 8'h00, 16'h0001), PREDICT, out_word_t'('0)},
      {arrive_word(8'h10, 8'h07, 16'h0002), PREDICT, out_word_t'('0)},
      {arrive_word(8'h11, 8'h07, 16'h0000), PREDICT, out_word_t'('0)},
      {arrive_word(8'h12, 8'h01, 16'h0001), PREDICT, out_word_t'('0)},
      {arrive_word(8'h13, 8'hFE, 16'h0002), PREDICT, out_word_t'('0)},
      {arrive_word(8'h14, 8'h03, 16'h0001), PREDICT, out_word_t'('0)},
      {arrive_word(8'h15, 8'h03, 16'h0003), PREDICT, out_word_t'('0)},
      {arrive_word(8'h16, 8'h80, 16'h0000), PREDICT, out_word_t'('0)},
      {arrive_word(8'h17, 8'h7F, 16'h0001), PREDICT, out_word_t'('0)},
      {arrive_word(8'h18, 8'h02, 16'h0002), PREDICT, out_word_t'('0)},
      {arrive_word(8'h19, 8'h01, 16'h0001), PREDICT, out_word_t'('0)},
      {arrive_word(8'h1A, 8'h40, 16'h0000), PREDICT, out_word_t'('0)},
      {arrive_word(8'h1B, 8'h00, 16'h0002), PREDICT, out_word_t'('0)},
      // table full: drop
      {arrive_word(8'hFF, 8'hFF, 16'hFFFF), TYPED,   quiet_res(1'b0, 32'd0, 5'd16)}
    };
  end

  initial begin
    int idle_pct[4];
    int hold_pct[4];
    int arrive_pct;
    idle_pct = '{0, 75, 0, 27};
    hold_pct = '{0, 0, 75, 27};
    arrive_pct = 50;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r])
      send_word(directed_rows[r].word, directed_rows[r].typed, directed_rows[r].res);

    for (int p = 0; p < 4; p++) begin
      // hold the sender until the block has drained
      in_valid <= 1'b0;
      wait_drained();
      send_idle_pct = idle_pct[p];
      stall_pct     = hold_pct[p];
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 50 == 0) arrive_pct = 30 + 20 * $urandom_range(2);
        send_word(random_word(arrive_pct), PREDICT, out_word_t'('0));
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && sched_results_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("TIMEOUT with %0d results outstanding", sched_results_due.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
